>>> design/oaht_pkg.sv
package oaht_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int KIND_W        = 2;
    localparam int KEY_W         = 32;
    localparam int HASH_W        = 32;
    localparam int VAL_W         = 64;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    // slot status codes
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_id;
        logic [HASH_W-1:0] key_hash;
        logic [VAL_W-1:0]  new_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value_out;
        logic             table_full;
    } rsp_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MODR,
        ST_PROBE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic load_req;
        logic calc_q;
        logic calc_start;
        logic probe_en;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic quick;
        logic probe_done;
    } dp_status_t;

endpackage

>>> design/oaht_ram.sv
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/oaht_ctrl.sv
module oaht_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  oaht_pkg::dp_status_t   status,
    output oaht_pkg::ctrl_cmd_t    cmd
);

    import oaht_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_MODR;
            end
            ST_MODR:
            begin
                state_next = status.quick ? ST_FINISH : ST_PROBE;
            end
            ST_PROBE:
            begin
                if (status.probe_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_CALC:
            begin
                cmd.calc_q = 1'b1;
            end
            ST_MODR:
            begin
                cmd.calc_start = 1'b1;
            end
            ST_PROBE:
            begin
                cmd.probe_en = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over an untaken transaction");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside of finish");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req_ready && !cmd.finish)
        else $error("activity during clearing pass");

endmodule

>>> design/oaht_dp.sv
module oaht_dp #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  oaht_pkg::req_t        req,
    output oaht_pkg::rsp_t        rsp,
    input  oaht_pkg::ctrl_cmd_t   cmd,
    output oaht_pkg::dp_status_t  status
);

    import oaht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] LOAD_MAX = CNT_W'((3 * SLOTS) / 4);
    localparam logic [63:0]      RECIP_W  = (64'd1 << 32) / 64'(SLOTS);
    localparam logic [31:0]      RECIP    = RECIP_W[31:0];
    localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    req_t             req_reg;
    rsp_t             rsp_reg;
    logic [31:0]      q_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] n_reg;
    logic             dv_reg;
    logic             tomb_valid_reg;
    logic [IDX_W-1:0] tomb_reg;
    logic             found_reg;
    logic             noslot_reg;
    logic             target_empty_reg;
    logic [IDX_W-1:0] target_reg;
    logic [VAL_W-1:0] value_reg;
    logic [IDX_W-1:0] clr_reg;
    logic [CNT_W-1:0] count_reg;

    logic [63:0]      prod;
    logic [IDX_W:0]   qs_low;
    logic [IDX_W:0]   diff;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] addr_inc;

    logic [SLOT_W-1:0] rd_word;
    slot_t             rd_slot;
    logic              is_empty;
    logic              is_tomb;
    logic              is_match;
    logic              tomb_any;
    logic [IDX_W-1:0]  tomb_idx;

    logic              is_set;
    logic              is_get;
    logic              is_del;
    logic              over;
    logic              quick;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    slot_t             wslot;
    rsp_t              rsp_next;

    // start slot = hash mod SLOTS: quotient estimate is low by at most one
    assign prod      = {32'd0, req_reg.key_hash} * {32'd0, RECIP};
    assign qs_low    = q_reg[IDX_W:0] * SLOTS_X;
    assign diff      = req_reg.key_hash[IDX_W:0] - qs_low;
    assign start_idx = (diff >= SLOTS_X) ? IDX_W'(diff - SLOTS_X) : diff[IDX_W-1:0];
    assign addr_inc  = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;

    assign rd_slot  = slot_t'(rd_word);
    assign is_empty = rd_slot.status == SLOT_EMPTY;
    assign is_tomb  = rd_slot.status == SLOT_TOMB;
    assign is_match = (rd_slot.status == SLOT_LIVE) && (rd_slot.key == req_reg.key_id);
    assign tomb_any = tomb_valid_reg || is_tomb;
    assign tomb_idx = tomb_valid_reg ? tomb_reg : cur_reg;

    assign is_set = req_reg.kind == KIND_SET;
    assign is_get = req_reg.kind == KIND_GET;
    assign is_del = req_reg.kind == KIND_DEL;
    assign over   = count_reg >= LOAD_MAX;
    assign quick  = (is_set && over) || (!is_set && !is_get && !is_del)
                    || ((is_get || is_del) && count_reg == '0);

    assign status.clear_last = clr_reg == LAST_IDX;
    assign status.quick      = quick;
    assign status.probe_done = dv_reg && (is_empty || is_match || n_reg == LAST_IDX);

    always_comb
    begin
        we    = 1'b0;
        waddr = target_reg;
        wslot = '0;
        if (cmd.clear_en)
        begin
            we    = 1'b1;
            waddr = clr_reg;
        end
        else if (cmd.finish && !quick)
        begin
            if (is_set && !noslot_reg)
            begin
                we           = 1'b1;
                wslot.status = SLOT_LIVE;
                wslot.key    = req_reg.key_id;
                wslot.value  = req_reg.new_value;
            end
            else if (is_del && found_reg)
            begin
                we           = 1'b1;
                wslot.status = SLOT_TOMB;
            end
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (is_set)
        begin
            rsp_next.table_full = quick || noslot_reg;
            rsp_next.hit        = !quick && !found_reg && !noslot_reg;
        end
        else if (!quick)
        begin
            rsp_next.hit = found_reg;
            if (is_get && found_reg)
            begin
                rsp_next.value_out = value_reg;
            end
        end
    end

    oaht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (SLOT_W'(wslot)),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.calc_start)
            begin
                dv_reg <= 1'b0;
            end
            else if (cmd.probe_en)
            begin
                dv_reg <= 1'b1;
            end
            if (cmd.finish && !quick && is_set && !found_reg && !noslot_reg
                && target_empty_reg)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.calc_q)
        begin
            q_reg <= prod[63:32];
        end
        if (cmd.calc_start)
        begin
            addr_reg       <= start_idx;
            n_reg          <= '0;
            tomb_valid_reg <= 1'b0;
        end
        else if (cmd.probe_en)
        begin
            // keep reads streaming; the read after the stop is dropped
            addr_reg <= addr_inc;
            cur_reg  <= addr_reg;
            if (dv_reg)
            begin
                n_reg <= n_reg + 1'b1;
                if (is_tomb && !tomb_valid_reg)
                begin
                    tomb_valid_reg <= 1'b1;
                    tomb_reg       <= cur_reg;
                end
                if (status.probe_done)
                begin
                    found_reg        <= is_match;
                    value_reg        <= rd_slot.value;
                    target_reg       <= is_match ? cur_reg : (tomb_any ? tomb_idx : cur_reg);
                    target_empty_reg <= !is_match && !tomb_any && is_empty;
                    noslot_reg       <= !is_match && !tomb_any && !is_empty;
                end
            end
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LOAD_MAX)
        else $error("used count past load limit");

    a_no_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_en |-> !we)
        else $error("slot write during probe");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(cmd.finish) && $past(is_set))
        else $error("used count moved outside a set");

endmodule

>>> design/open_addressing_hash_table_unit.sv
// Open-addressing hash table, linear probing with tombstones, SLOTS entries in one
// slot RAM (status, key, value). After reset a clearing pass, during which no
// request is accepted, writes every slot empty. A request passes through accept, a
// quotient multiply, a start-slot step, the probe and a finish step; one that
// needs no probe (refused set, get or delete on an empty table, unused kind) skips
// the probe. The probe streams one slot per cycle through the registered RAM
// read port. The finish step waits until the output register is free, then writes
// the slot where the request changes it and loads the output register, which may
// hold a result while the next request is accepted.
module open_addressing_hash_table_unit #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  oaht_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output oaht_pkg::rsp_t rsp
);

    import oaht_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    oaht_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

>>> bench/open_addressing_hash_table_unit_tb.sv
`timescale 1ns / 1ps

module open_addressing_hash_table_unit_tb;

    import oaht_pkg::*;

    localparam int TBL_SLOTS = SLOTS_DEFAULT;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 2 * TBL_SLOTS + 16;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // shadow copy of the table
    logic [1:0]       tbl_status [TBL_SLOTS];
    logic [KEY_W-1:0] tbl_key    [TBL_SLOTS];
    logic [VAL_W-1:0] tbl_value  [TBL_SLOTS];
    int               tbl_used;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    logic [KEY_W-1:0]  pool_key  [$];
    logic [HASH_W-1:0] pool_hash [$];

    int burst_left, gap_left;
    int n_accepted, n_results, n_errors, n_cycles;
    int n_inserted, n_overwritten, n_refused, n_found, n_missed, peak_used;
    int hold_left, pat_age;
    bit hold_done;
    logic [15:0] stall_pat;

    open_addressing_hash_table_unit #(.SLOTS(TBL_SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Return the live slot holding the key (found = 1), else the slot a set
    // would take, or -1 when there is none.
    function automatic int find_slot(input logic [KEY_W-1:0] key,
                                     input logic [HASH_W-1:0] hash, output bit found);
        int idx;
        int tomb;
        idx = int'(hash % 32'(TBL_SLOTS));
        tomb = -1;
        found = 1'b0;
        for (int n = 0; n < TBL_SLOTS; n++)
        begin
            if (tbl_status[idx] == SLOT_EMPTY)
                return (tomb >= 0) ? tomb : idx;
            if (tbl_status[idx] == SLOT_LIVE)
            begin
                if (tbl_key[idx] == key)
                begin
                    found = 1'b1;
                    return idx;
                end
            end
            else if (tomb < 0)
                tomb = idx;
            idx = (idx + 1) % TBL_SLOTS;
        end
        return tomb;
    endfunction

    function automatic rsp_t lookup_update(input req_t r);
        rsp_t o;
        int idx;
        bit found;
        o = '0;
        case (r.kind)
            KIND_SET:
            begin
                // load limit is checked before the probe
                if (4 * (tbl_used + 1) > 3 * TBL_SLOTS)
                    o.table_full = 1'b1;
                else
                begin
                    idx = find_slot(r.key_id, r.key_hash, found);
                    if (idx < 0)
                        o.table_full = 1'b1;
                    else
                    begin
                        if (!found)
                        begin
                            o.hit = 1'b1;
                            if (tbl_status[idx] == SLOT_EMPTY)
                                tbl_used++;
                        end
                        tbl_status[idx] = SLOT_LIVE;
                        tbl_key[idx]    = r.key_id;
                        tbl_value[idx]  = r.new_value;
                    end
                end
                if (o.table_full)
                    n_refused++;
                else if (o.hit)
                    n_inserted++;
                else
                    n_overwritten++;
                if (tbl_used > peak_used)
                    peak_used = tbl_used;
            end
            KIND_GET, KIND_DEL:
            begin
                if (tbl_used != 0)
                begin
                    idx = find_slot(r.key_id, r.key_hash, found);
                    if (found)
                    begin
                        o.hit = 1'b1;
                        if (r.kind == KIND_GET)
                            o.value_out = tbl_value[idx];
                        else
                            tbl_status[idx] = SLOT_TOMB;
                    end
                end
                if (o.hit)
                    n_found++;
                else
                    n_missed++;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic add_req(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] value);
        req_t r;
        r.kind      = kind;
        r.key_id    = key;
        r.key_hash  = hash;
        r.new_value = value;
        pending_reqs.push_back(r);
    endtask

    // Hash with a random upper part; in two of three cases the start slot lies near
    // one end of the table so that probes collide and wrap.
    function automatic logic [HASH_W-1:0] clustered_hash();
        logic [HASH_W-1:0] h;
        h = $urandom();
        case ($urandom_range(0, 2))
            0:       h[5:0] = 6'($urandom_range(TBL_SLOTS - 6, TBL_SLOTS - 1));
            1:       h[5:0] = 6'($urandom_range(0, 5));
            default: ;
        endcase
        return h;
    endfunction

    task automatic add_pool_op(input int pick);
        int p;
        p = $urandom_range(0, pool_key.size() - 1);
        if (pick < 40)
            add_req(KIND_SET, pool_key[p], pool_hash[p], random_value());
        else if (pick < 72)
            add_req(KIND_GET, pool_key[p], pool_hash[p], random_value());
        else if (pick < 92)
            add_req(KIND_DEL, pool_key[p], pool_hash[p], random_value());
        else if (pick < 97)
            add_req($urandom_range(0, 1) ? KIND_GET : KIND_DEL, $urandom(), $urandom(),
                    random_value());
        else
            add_req(KIND_NONE, $urandom(), $urandom(), random_value());
    endtask

    initial
    begin
        for (int i = 0; i < TBL_SLOTS; i++)
            tbl_status[i] = SLOT_EMPTY;
        tbl_used = 0;

        // directed: empty table, unused kind, field extremes, wrap, overwrite, tombstones
        add_req(KIND_GET,  32'h0, 32'h0, '0);
        add_req(KIND_DEL,  '1, '1, '1);
        add_req(KIND_NONE, '1, '1, '1);
        add_req(KIND_SET,  32'h0, 32'h0, '1);
        add_req(KIND_SET,  '1, '1, '0);
        add_req(KIND_SET,  32'h0000_1234, '1, 64'hA5A5_5A5A_F00D_1234);
        add_req(KIND_GET,  '1, '1, '0);
        add_req(KIND_GET,  32'h0000_1234, '1, '0);
        add_req(KIND_SET,  32'h0, 32'h0, 64'h5555_5555_5555_5555);
        add_req(KIND_GET,  32'h0, 32'h0, '0);
        add_req(KIND_DEL,  '1, '1, '0);
        add_req(KIND_DEL,  '1, '1, '0);
        add_req(KIND_GET,  32'h0000_1234, '1, '0);
        add_req(KIND_SET,  32'h0000_CAFE, 32'h0000_003F, 64'hAAAA_AAAA_AAAA_AAAA);
        add_req(KIND_SET,  32'h0000_1234, '1, 64'h0123_4567_89AB_CDEF);
        add_req(KIND_GET,  32'h0000_1234, 32'h8000_003F, '0);
        add_req(KIND_GET,  32'h0000_DEAD, 32'h0000_003F, '0);
        add_req(KIND_NONE, '0, '0, '0);
        add_req(KIND_DEL,  32'h0, 32'h0, '0);
        add_req(KIND_SET,  32'h0, 32'hFFFF_FFC0, 64'h8000_0000_0000_0001);
        add_req(KIND_GET,  32'h0, 32'h0, '0);
        add_req(KIND_GET,  32'h0000_CAFE, 32'h0000_003F, '0);

        // random: a small working set of keys churns through set, get and delete, mixed with misses and unused kinds
        for (int i = 0; i < 20; i++)
        begin
            pool_key.push_back($urandom());
            pool_hash.push_back(clustered_hash());
        end
        for (int i = 0; i < 750; i++)
            add_pool_op($urandom_range(0, 99));

        // then fresh keys fill the table up to its load limit, so that sets are refused
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                pool_key.push_back($urandom());
                pool_hash.push_back($urandom_range(0, 1) ? clustered_hash() : $urandom());
                add_req(KIND_SET, pool_key[$], pool_hash[$], random_value());
            end
            else
                add_pool_op($urandom_range(0, 99));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions: %0d inserts, %0d overwrites, %0d refused sets",
                 n_accepted, n_inserted, n_overwritten, n_refused);
        $display("%0d lookups/deletes found, %0d missed, peak used count %0d of %0d",
                 n_found, n_missed, peak_used, TBL_SLOTS);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(lookup_update(req));
                n_accepted++;
            end
            // hold the payload until the transaction is taken
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, reloaded now and then, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_pat <= '1;
            pat_age   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_results == 150)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= stall_pat[0];
            pat_age   <= (pat_age + 1) % 64;
            if (pat_age == 63)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pat <= '1;
                    1:       stall_pat <= 16'($urandom());
                    default: stall_pat <= 16'($urandom() | $urandom());
                endcase
            end
            else
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_results <= n_results + 1;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: result with none outstanding: hit=%0b value_out=%h table_full=%0b",
                         $time, rsp.hit, rsp.value_out, rsp.table_full);
                n_errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp.hit);
                    n_errors++;
                end
                if (rsp.value_out !== want.value_out)
                begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value_out, rsp.value_out);
                    n_errors++;
                end
                if (rsp.table_full !== want.table_full)
                begin
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, want.table_full, rsp.table_full);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles == LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles, %0d accepted, %0d still outstanding",
                     $time, n_cycles, n_accepted, expected_rsps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
